>>> rtl/sst_pkg.sv
// sorted set statistics: shared widths, defaults and sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    // field widths of a request and of a result
    localparam int VALUE_W  = 32;
    localparam int TOTAL_W  = 8;
    localparam int SUM_O_W  = 39;
    localparam int MEAN_W   = 39;
    localparam int MED_W    = 33;
    localparam int MCOUNT_W = 8;
    localparam int REP_W    = 7;

    // default store depth
    localparam int MAX_ITEMS_DEF = 128;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_WALK_END,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/sst_in_if.sv
// input channel: one signed value per request
// depends on sst_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sst_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sst_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/sst_out_if.sv
// result channel: statistics of one closed set per request
// depends on sst_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sst_out_if;
    logic                                valid;
    logic                                ready;
    logic                                empty_res;
    logic        [sst_pkg::TOTAL_W-1:0]  item_total;
    logic signed [sst_pkg::SUM_O_W-1:0]  total_sum;
    logic signed [sst_pkg::MEAN_W-1:0]   mean_hundredths;
    logic signed [sst_pkg::VALUE_W-1:0]  smallest;
    logic signed [sst_pkg::VALUE_W-1:0]  largest;
    logic signed [sst_pkg::MED_W-1:0]    median_doubled;
    logic signed [sst_pkg::VALUE_W-1:0]  mode_value;
    logic        [sst_pkg::MCOUNT_W-1:0] mode_count;
    logic        [sst_pkg::REP_W-1:0]    repeated_distinct;

    modport source (output valid, output empty_res, output item_total, output total_sum,
                    output mean_hundredths, output smallest, output largest,
                    output median_doubled, output mode_value, output mode_count,
                    output repeated_distinct, input ready);
    modport sink   (input valid, input empty_res, input item_total, input total_sum,
                    input mean_hundredths, input smallest, input largest,
                    input median_doubled, input mode_value, input mode_count,
                    input repeated_distinct, output ready);
endinterface

`default_nettype wire

>>> rtl/sst_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sst_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sst_div #(
    parameter int DW = 48,
    parameter int VW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output      logic          done,
    output      logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;

    // one shift and trial subtract per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            rem_next = trial[VW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_set_statistics.sv
// sorted set statistics: top level sequencer, sorted store and result register
// depends on sst_pkg, sst_in_if, sst_out_if, sst_ram, sst_div
// a nonzero value is inserted into the sorted store: each larger value is read and moved up
// one place, then the value is written to the freed place, address 0 for a new lowest entry
// a closing request of a nonempty set walks the store, scales the sum and runs the divider
// (DW = 40 + clog2(MAX_ITEMS + 1)); every closing request then loads the result register
// requests are taken one at a time; a pending result blocks values only after a set closes
// reset clears count, sum, result valid and sequencer; the store needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_statistics #(
    parameter int MAX_ITEMS = sst_pkg::MAX_ITEMS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sst_in_if.sink     in_chan,
    sst_out_if.source  out_chan
);
    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = sst_pkg::VALUE_W + CNT_W;
    localparam int DW    = SUM_W + 8;
    localparam int VW    = CNT_W + 1;
    localparam int VAL_W = sst_pkg::VALUE_W;
    localparam int MED_W = sst_pkg::MED_W;

    sst_pkg::state_t state_reg, state_next;

    logic        [CNT_W-1:0] count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic        [AW-1:0]    j_reg, j_next;
    logic        [AW-1:0]    i_reg, i_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic        [CNT_W-1:0] run_reg, run_next;
    logic signed [VAL_W-1:0] mode_v_reg, mode_v_next;
    logic        [CNT_W-1:0] mode_c_reg, mode_c_next;
    logic        [CNT_W-1:0] reps_reg, reps_next;
    logic signed [VAL_W-1:0] min_reg, min_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic signed [MED_W-1:0] med_reg, med_next;
    logic        [SUM_W-1:0] mag_reg, mag_next;
    logic        [DW-1:0]    dvd_reg, dvd_next;
    logic                    empty_reg, empty_next;

    logic                                   ov_reg, ov_next;
    logic                                   o_empty_reg, o_empty_next;
    logic        [sst_pkg::TOTAL_W-1:0]     o_total_reg, o_total_next;
    logic signed [sst_pkg::SUM_O_W-1:0]     o_sum_reg, o_sum_next;
    logic signed [sst_pkg::MEAN_W-1:0]      o_mean_reg, o_mean_next;
    logic signed [VAL_W-1:0]                o_min_reg, o_min_next;
    logic signed [VAL_W-1:0]                o_max_reg, o_max_next;
    logic signed [MED_W-1:0]                o_med_reg, o_med_next;
    logic signed [VAL_W-1:0]                o_mode_reg, o_mode_next;
    logic        [sst_pkg::MCOUNT_W-1:0]    o_mcnt_reg, o_mcnt_next;
    logic        [sst_pkg::REP_W-1:0]       o_reps_reg, o_reps_next;

    // memory and divider hookup
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;
    logic             div_done;
    logic [DW-1:0]    div_q;

    // helper values
    logic signed [VAL_W-1:0] s;
    logic        [CNT_W-1:0] i_ext, cnt_inc, mid_lo, mid_hi;
    logic signed [MED_W-1:0] s_wide;
    logic                    ins_done;
    logic                    run_flush;
    logic [CNT_W+sst_pkg::TOTAL_W-1:0]  total_ext;
    logic [CNT_W+sst_pkg::MCOUNT_W-1:0] mcnt_ext;
    logic [CNT_W+sst_pkg::REP_W-1:0]    reps_ext;
    logic [SUM_W+sst_pkg::SUM_O_W-1:0]  sum_ext;
    logic [DW:0]                        q_signed;
    logic [DW+1+sst_pkg::MEAN_W-1:0]    mean_ext;

    sst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sst_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == sst_pkg::ST_DIV_GO),
        .dividend (dvd_reg),
        .divisor  ({count_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s       = $signed(ram_rdata);
    assign s_wide  = {s[VAL_W-1], s};
    assign i_ext   = CNT_W'(i_reg);
    assign cnt_inc = count_reg + 1'b1;
    assign mid_lo  = (count_reg - 1'b1) >> 1;
    assign mid_hi  = count_reg >> 1;

    // field fitting for the result register
    assign total_ext = {{sst_pkg::TOTAL_W{1'b0}}, count_reg};
    assign mcnt_ext  = {{sst_pkg::MCOUNT_W{1'b0}}, mode_c_reg};
    assign reps_ext  = {{sst_pkg::REP_W{1'b0}}, reps_reg};
    assign sum_ext   = {{sst_pkg::SUM_O_W{sum_reg[SUM_W-1]}}, sum_reg};
    assign q_signed  = sum_reg[SUM_W-1] ? (~{1'b0, div_q} + 1'b1) : {1'b0, div_q};
    assign mean_ext  = {{sst_pkg::MEAN_W{q_signed[DW]}}, q_signed};

    // sequencer: next state and working registers
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        key_next     = key_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        prev_next    = prev_reg;
        run_next     = run_reg;
        mode_v_next  = mode_v_reg;
        mode_c_next  = mode_c_reg;
        reps_next    = reps_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        med_next     = med_reg;
        mag_next     = mag_reg;
        dvd_next     = dvd_reg;
        empty_next   = empty_reg;
        ov_next      = ov_reg;
        o_empty_next = o_empty_reg;
        o_total_next = o_total_reg;
        o_sum_next   = o_sum_reg;
        o_mean_next  = o_mean_reg;
        o_min_next   = o_min_reg;
        o_max_next   = o_max_reg;
        o_med_next   = o_med_reg;
        o_mode_next  = o_mode_reg;
        o_mcnt_next  = o_mcnt_reg;
        o_reps_next  = o_reps_reg;
        ram_we       = 1'b0;
        ram_waddr    = j_reg;
        ram_wdata    = key_reg;
        ram_raddr    = j_reg;
        ins_done     = 1'b0;
        run_flush    = 1'b0;

        // result taken by the sink
        if (ov_reg && out_chan.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (in_chan.valid)
                begin
                    if (in_chan.value == '0)
                    begin
                        i_next      = '0;
                        run_next    = '0;
                        mode_c_next = '0;
                        reps_next   = '0;
                        med_next    = '0;
                        if (count_reg == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = sst_pkg::ST_EMIT;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            state_next = sst_pkg::ST_WALK_RD;
                        end
                    end
                    else
                    begin
                        key_next   = in_chan.value;
                        sum_next   = sum_reg + SUM_W'(in_chan.value);
                        j_next     = count_reg[AW-1:0];
                        state_next = sst_pkg::ST_INS_RD;
                    end
                end
            end

            // insertion: move larger entries up one place
            sst_pkg::ST_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    ram_we   = 1'b1;
                    ins_done = 1'b1;
                end
                else
                begin
                    ram_raddr  = j_reg - 1'b1;
                    state_next = sst_pkg::ST_INS_CMP;
                end
            end

            sst_pkg::ST_INS_CMP:
            begin
                ram_we = 1'b1;
                if (s > key_reg)
                begin
                    ram_wdata  = ram_rdata;
                    j_next     = j_reg - 1'b1;
                    state_next = sst_pkg::ST_INS_RD;
                end
                else
                begin
                    ins_done = 1'b1;
                end
            end

            // walk over the sorted store
            sst_pkg::ST_WALK_RD:
            begin
                ram_raddr  = i_reg;
                state_next = sst_pkg::ST_WALK_CMP;
            end

            sst_pkg::ST_WALK_CMP:
            begin
                if (i_reg == '0)
                begin
                    min_next = s;
                end
                if (i_ext == count_reg - 1'b1)
                begin
                    max_next   = s;
                    state_next = sst_pkg::ST_WALK_END;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = sst_pkg::ST_WALK_RD;
                end
                med_next = med_reg + ((i_ext == mid_lo) ? s_wide : '0)
                                   + ((i_ext == mid_hi) ? s_wide : '0);
                if (i_reg == '0 || s != prev_reg)
                begin
                    run_flush = (i_reg != '0);
                    run_next  = CNT_W'(1);
                    prev_next = s;
                end
                else
                begin
                    run_next = run_reg + 1'b1;
                    if (run_reg == CNT_W'(1))
                    begin
                        reps_next = reps_reg + 1'b1;
                    end
                end
            end

            sst_pkg::ST_WALK_END:
            begin
                run_flush  = 1'b1;
                mag_next   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
                state_next = sst_pkg::ST_SCALE;
            end

            // 200 times the magnitude plus n, ready for division by 2n
            sst_pkg::ST_SCALE:
            begin
                dvd_next = ({1'b0, mag_reg, 7'b0} + {2'b0, mag_reg, 6'b0})
                         + ({5'b0, mag_reg, 3'b0} + DW'(count_reg));
                state_next = sst_pkg::ST_DIV_GO;
            end

            sst_pkg::ST_DIV_GO:
            begin
                state_next = sst_pkg::ST_DIV;
            end

            sst_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = sst_pkg::ST_EMIT;
                end
            end

            // load the result register once it is free
            sst_pkg::ST_EMIT:
            begin
                if (!ov_reg || out_chan.ready)
                begin
                    ov_next      = 1'b1;
                    o_empty_next = empty_reg;
                    if (empty_reg)
                    begin
                        o_total_next = '0;
                        o_sum_next   = '0;
                        o_mean_next  = '0;
                        o_min_next   = '0;
                        o_max_next   = '0;
                        o_med_next   = '0;
                        o_mode_next  = '0;
                        o_mcnt_next  = '0;
                        o_reps_next  = '0;
                    end
                    else
                    begin
                        o_total_next = total_ext[sst_pkg::TOTAL_W-1:0];
                        o_sum_next   = sum_ext[sst_pkg::SUM_O_W-1:0];
                        o_mean_next  = mean_ext[sst_pkg::MEAN_W-1:0];
                        o_min_next   = min_reg;
                        o_max_next   = max_reg;
                        o_med_next   = med_reg;
                        o_mode_next  = mode_v_reg;
                        o_mcnt_next  = mcnt_ext[sst_pkg::MCOUNT_W-1:0];
                        o_reps_next  = reps_ext[sst_pkg::REP_W-1:0];
                    end
                    count_next = '0;
                    sum_next   = '0;
                    state_next = sst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase

        // close of a run of equal values
        if (run_flush && run_reg > mode_c_reg)
        begin
            mode_c_next = run_reg;
            mode_v_next = prev_reg;
        end

        // value placed; a full store closes the set
        if (ins_done)
        begin
            count_next = cnt_inc;
            if (cnt_inc == CNT_W'(MAX_ITEMS))
            begin
                i_next      = '0;
                run_next    = '0;
                mode_c_next = '0;
                reps_next   = '0;
                med_next    = '0;
                empty_next  = 1'b0;
                state_next  = sst_pkg::ST_WALK_RD;
            end
            else
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        j_reg       <= j_next;
        i_reg       <= i_next;
        prev_reg    <= prev_next;
        run_reg     <= run_next;
        mode_v_reg  <= mode_v_next;
        mode_c_reg  <= mode_c_next;
        reps_reg    <= reps_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        med_reg     <= med_next;
        mag_reg     <= mag_next;
        dvd_reg     <= dvd_next;
        empty_reg   <= empty_next;
        o_empty_reg <= o_empty_next;
        o_total_reg <= o_total_next;
        o_sum_reg   <= o_sum_next;
        o_mean_reg  <= o_mean_next;
        o_min_reg   <= o_min_next;
        o_max_reg   <= o_max_next;
        o_med_reg   <= o_med_next;
        o_mode_reg  <= o_mode_next;
        o_mcnt_reg  <= o_mcnt_next;
        o_reps_reg  <= o_reps_next;
    end

    // channel outputs
    assign in_chan.ready              = (state_reg == sst_pkg::ST_IDLE);
    assign out_chan.valid             = ov_reg;
    assign out_chan.empty_res         = o_empty_reg;
    assign out_chan.item_total        = o_total_reg;
    assign out_chan.total_sum         = o_sum_reg;
    assign out_chan.mean_hundredths   = o_mean_reg;
    assign out_chan.smallest          = o_min_reg;
    assign out_chan.largest           = o_max_reg;
    assign out_chan.median_doubled    = o_med_reg;
    assign out_chan.mode_value        = o_mode_reg;
    assign out_chan.mode_count        = o_mcnt_reg;
    assign out_chan.repeated_distinct = o_reps_reg;

endmodule

`default_nettype wire

>>> tb/tb_sorted_set_statistics.sv
// testbench for sorted_set_statistics: drives value requests, predicts each set's statistics
// depends on sst_pkg, sst_in_if, sst_out_if and the block itself
`timescale 1ns / 1ps

module tb_sorted_set_statistics;

    localparam int DEPTH = sst_pkg::MAX_ITEMS_DEF;

    typedef struct packed {
        logic                                empty_res;
        logic [sst_pkg::TOTAL_W-1:0]         item_total;
        logic signed [sst_pkg::SUM_O_W-1:0]  total_sum;
        logic signed [sst_pkg::MEAN_W-1:0]   mean_hundredths;
        logic signed [sst_pkg::VALUE_W-1:0]  smallest;
        logic signed [sst_pkg::VALUE_W-1:0]  largest;
        logic signed [sst_pkg::MED_W-1:0]    median_doubled;
        logic signed [sst_pkg::VALUE_W-1:0]  mode_value;
        logic [sst_pkg::MCOUNT_W-1:0]        mode_count;
        logic [sst_pkg::REP_W-1:0]           repeated_distinct;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sst_in_if  in_chan();
    sst_out_if out_chan();

    sorted_set_statistics u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    always #10 clk = ~clk;

    // pending requests, predicted results and the open set
    logic signed [sst_pkg::VALUE_W-1:0] value_queue[$];
    stats_t                             stats_queue[$];
    logic signed [sst_pkg::VALUE_W-1:0] open_set[$];
    int  errors = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  recv_hold = 1'b0;
    bit  hold_start = 1'b0;
    bit  stim_done = 1'b0;
    bit  tx_valid = 1'b0;

    // statistics of a closed set, sorted here by a plain insertion pass
    function automatic stats_t set_statistics(logic signed [sst_pkg::VALUE_W-1:0] vals[$]);
        stats_t r;
        longint s[$];
        longint sum, mag, q, key, cur, lo, hi, med, mode_v;
        int n, i, j, run, best, reps;
        r = '0;
        n = vals.size();
        if (n == 0)
        begin
            r.empty_res = 1'b1;
            return r;
        end
        sum = 0;
        foreach (vals[k])
        begin
            s.push_back(longint'(vals[k]));
            sum += longint'(vals[k]);
        end
        for (i = 1; i < n; i++)
        begin
            key = s[i];
            j = i;
            while (j > 0 && s[j-1] > key)
            begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = key;
        end
        mag = (sum < 0) ? -sum : sum;
        q = (mag * 200 + n) / (2 * n);
        if (sum < 0)
            q = -q;
        lo = s[0];
        hi = s[n-1];
        med = (n % 2) ? 2 * s[n/2] : s[n/2-1] + s[n/2];
        r.item_total = n[sst_pkg::TOTAL_W-1:0];
        r.total_sum = sum[sst_pkg::SUM_O_W-1:0];
        r.mean_hundredths = q[sst_pkg::MEAN_W-1:0];
        r.smallest = lo[sst_pkg::VALUE_W-1:0];
        r.largest = hi[sst_pkg::VALUE_W-1:0];
        r.median_doubled = med[sst_pkg::MED_W-1:0];
        best = 0;
        reps = 0;
        mode_v = s[0];
        i = 0;
        while (i < n)
        begin
            cur = s[i];
            run = 0;
            while (i < n && s[i] == cur)
            begin
                run++;
                i++;
            end
            if (run > best)
            begin
                best = run;
                mode_v = cur;
            end
            if (run > 1)
                reps++;
        end
        r.mode_value = mode_v[sst_pkg::VALUE_W-1:0];
        r.mode_count = best[sst_pkg::MCOUNT_W-1:0];
        r.repeated_distinct = reps[sst_pkg::REP_W-1:0];
        return r;
    endfunction

    // predict on every accepted request
    task automatic note_value(logic signed [sst_pkg::VALUE_W-1:0] v);
        if (v != 0)
            open_set.push_back(v);
        if (v == 0 || open_set.size() == DEPTH)
        begin
            stats_queue.push_back(set_statistics(open_set));
            open_set.delete();
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan.valid <= 1'b0;
            in_chan.value <= '0;
            tx_valid = 1'b0;
        end
        else
        begin
            if (tx_valid && in_chan.ready)
            begin
                note_value(in_chan.value);
                void'(value_queue.pop_front());
                tx_valid = 1'b0;
            end
            if (!tx_valid && value_queue.size() > 0 &&
                $urandom_range(99, 0) >= send_idle)
            begin
                in_chan.value <= value_queue[0];
                tx_valid = 1'b1;
            end
            in_chan.valid <= tx_valid;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        stats_t got, want;
        if (!rst_n)
            out_chan.ready <= 1'b0;
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                got = {out_chan.empty_res, out_chan.item_total, out_chan.total_sum,
                       out_chan.mean_hundredths, out_chan.smallest, out_chan.largest,
                       out_chan.median_doubled, out_chan.mode_value, out_chan.mode_count,
                       out_chan.repeated_distinct};
                if (stats_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    want = stats_queue.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            out_chan.ready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle);
        end
    end

    // long receiver stall, counted in cycles here
    initial
    begin
        wait (hold_start);
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
    end

    function automatic logic signed [sst_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(5, 0))
            0: return $urandom_range(20, 1);
            1: return -$signed($urandom_range(20, 1));
            2: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom();
        endcase
    endfunction

    // one set of n values, closed by zero unless it fills the store
    task automatic add_set(int n);
        for (int i = 0; i < n; i++)
        begin
            logic signed [sst_pkg::VALUE_W-1:0] v;
            v = rand_value();
            if (v == 0)
                v = 1;
            value_queue.push_back(v);
        end
        if (n < DEPTH)
            value_queue.push_back(0);
    endtask

    task automatic wait_drained();
        while (value_queue.size() > 0 || stats_queue.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // empty set, extremes, ties, odd and even, full store
        value_queue.push_back(0);
        value_queue.push_back(0);
        value_queue.push_back(32'sh7fffffff);
        value_queue.push_back(32'sh80000000);
        value_queue.push_back(32'sh80000000);
        value_queue.push_back(0);
        value_queue.push_back(-5);
        value_queue.push_back(3);
        value_queue.push_back(3);
        value_queue.push_back(-5);
        value_queue.push_back(7);
        value_queue.push_back(0);
        value_queue.push_back(-1);
        value_queue.push_back(-2);
        value_queue.push_back(0);
        value_queue.push_back(32'sh55555555);
        value_queue.push_back(0);
        for (int i = 0; i < DEPTH; i++)
            value_queue.push_back(32'sh7fffffff);
        wait_drained();
        // random phases with differing idling
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 35 : (ph == 1) ? 62 : 0;
            recv_idle = (ph == 0) ? 62 : (ph == 1) ? 35 : 0;
            for (int k = 0; k < 45; k++)
                add_set(($urandom_range(19, 0) == 0) ? DEPTH : $urandom_range(12, 0));
            if (ph == 2)
            begin
                // long receiver stall while values keep arriving
                hold_start = 1'b1;
            end
            wait_drained();
        end
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        repeat (500) @(posedge clk);
        if (errors == 0 && stats_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/sst_pkg.sv
rtl/sst_in_if.sv
rtl/sst_out_if.sv
rtl/sst_ram.sv
rtl/sst_div.sv
rtl/sorted_set_statistics.sv
tb/tb_sorted_set_statistics.sv
